>>> rtl/led_matrix_frame_and_scan_core_assert.svh
// ----------------------------------------------------------------------------
// LED matrix frame and scan core - assertion macros
// Short forms for same-cycle and next-cycle implications on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAME_AND_SCAN_CORE_ASSERT_SVH
`define LED_MATRIX_FRAME_AND_SCAN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmfs check failed");

// Consequent must hold in the cycle after the antecedent.
`define LMFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmfs check failed");

`endif

>>> rtl/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types, constants and glyph tables of the LED matrix frame core.
// ----------------------------------------------------------------------------
package lmfs_pkg;

    localparam int ROWS = 5;
    localparam int ROW_W = $clog2(ROWS);

    typedef logic [7:0] row_t;
    typedef logic [ROWS-1:0][7:0] frame_t;

    typedef enum logic [3:0] {
        OP_HOUR     = 4'd0,
        OP_MINUTE   = 4'd1,
        OP_SECOND   = 4'd2,
        OP_ADJ_HOUR = 4'd3,
        OP_ADJ_MIN  = 4'd4,
        OP_ADJ_SEC  = 4'd5,
        OP_CHAR     = 4'd6,
        OP_DIGIT    = 4'd7,
        OP_LOGO     = 4'd8,
        OP_CLEAR    = 4'd9,
        OP_SCAN     = 4'd10
    } lmfs_op_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] operand;
    } lmfs_cmd_t;

    typedef struct packed {
        logic hit;
        row_t row_pattern;
        row_t column_enable;
    } lmfs_scan_t;

    localparam row_t DIGIT_KEEP = 8'b1111_1000;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_H = 8'h48;
    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] NUM_DIGITS = 8'd10;
    localparam logic [7:0] NUM_ROWS = 8'd5;

    // Rows listed top (row 4) to bottom (row 0).
    localparam frame_t LOGO = {8'b0110_0010, 8'b1001_0101, 8'h84,
                               8'b1011_0101, 8'b0110_0010};

    function automatic row_t col_enable(input logic [ROW_W-1:0] r);
        row_t e;
        case (r)
            3'd0:    e = 8'b1111_1110;
            3'd1:    e = 8'hFD;
            3'd2:    e = 8'hFB;
            3'd3:    e = 8'b1011_1111;
            3'd4:    e = 8'b0111_1111;
            default: e = 8'hFF;
        endcase
        return e;
    endfunction

    function automatic frame_t letter_glyph(input logic [4:0] k);
        frame_t g;
        case (k)
            5'd0:    g = {8'h40, 8'hA0, 8'hE0, 8'hA0, 8'hA0};
            5'd1:    g = {8'hC0, 8'hA0, 8'hC0, 8'hA0, 8'hC0};
            5'd2:    g = {8'h40, 8'hA0, 8'h80, 8'hA0, 8'h40};
            5'd3:    g = {8'hC0, 8'hA0, 8'hA0, 8'hA0, 8'hC0};
            5'd4:    g = {8'hE0, 8'h80, 8'hE0, 8'h80, 8'hE0};
            5'd5:    g = {8'hE0, 8'h80, 8'hE0, 8'h80, 8'h80};
            5'd6:    g = {8'h40, 8'hA0, 8'h80, 8'hE0, 8'h40};
            5'd7:    g = {8'hA0, 8'hA0, 8'hE0, 8'hA0, 8'hA0};
            5'd8:    g = {8'h40, 8'h40, 8'h40, 8'h40, 8'hE0};
            5'd9:    g = {8'h20, 8'h20, 8'h20, 8'hA0, 8'h40};
            5'd10:   g = {8'hA0, 8'hC0, 8'h80, 8'hC0, 8'hA0};
            5'd11:   g = {8'h80, 8'h80, 8'h80, 8'h80, 8'hE0};
            5'd12:   g = {8'hA0, 8'hE0, 8'hA0, 8'hA0, 8'hA0};
            5'd13:   g = {8'hA0, 8'hE0, 8'hE0, 8'hA0, 8'hA0};
            5'd14:   g = {8'h40, 8'hA0, 8'hA0, 8'hA0, 8'h40};
            5'd15:   g = {8'hC0, 8'hA0, 8'hC0, 8'h80, 8'h80};
            5'd16:   g = {8'h40, 8'hA0, 8'hA0, 8'hA0, 8'h60};
            5'd17:   g = {8'hC0, 8'hA0, 8'hC0, 8'hC0, 8'hA0};
            5'd18:   g = {8'hE0, 8'h80, 8'h40, 8'h20, 8'hE0};
            5'd19:   g = {8'hE0, 8'h40, 8'h40, 8'h40, 8'hE0};
            5'd20:   g = {8'hA0, 8'hA0, 8'hA0, 8'hA0, 8'hE0};
            5'd21:   g = {8'hA0, 8'hA0, 8'hA0, 8'hA0, 8'h40};
            5'd22:   g = {8'hA0, 8'hA0, 8'hA0, 8'hE0, 8'hA0};
            5'd23:   g = {8'hA0, 8'hA0, 8'h40, 8'hA0, 8'hA0};
            5'd24:   g = {8'hA0, 8'hA0, 8'h40, 8'h40, 8'h40};
            5'd25:   g = {8'hE0, 8'h20, 8'h40, 8'h80, 8'hE0};
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic frame_t digit_glyph(input logic [3:0] d);
        frame_t g;
        case (d)
            4'd0:    g = {8'd2, 8'd5, 8'd5, 8'd5, 8'd2};
            4'd1:    g = {8'd2, 8'd2, 8'd2, 8'd2, 8'd2};
            4'd2:    g = {8'd6, 8'd1, 8'd2, 8'd4, 8'd7};
            4'd3:    g = {8'd6, 8'd1, 8'd2, 8'd1, 8'd6};
            4'd4:    g = {8'd5, 8'd5, 8'd7, 8'd1, 8'd1};
            4'd5:    g = {8'd7, 8'd4, 8'd6, 8'd1, 8'd6};
            4'd6:    g = {8'd2, 8'd4, 8'd6, 8'd5, 8'd2};
            4'd7:    g = {8'd7, 8'd1, 8'd2, 8'd2, 8'd2};
            4'd8:    g = {8'd2, 8'd5, 8'd2, 8'd5, 8'd2};
            4'd9:    g = {8'd2, 8'd5, 8'd3, 8'd1, 8'd2};
            default: g = '0;
        endcase
        return g;
    endfunction

    // Bit r goes to the low bit of the pair in row r, bit r+4 to the high bit.
    function automatic frame_t scatter_bcd(input frame_t f, input logic [7:0] v,
                                           input logic [2:0] low);
        frame_t o;
        o = f;
        for (int r = 0; r < 4; r++) begin
            o[r][low] = v[r];
            o[r][3'(low + 3'd1)] = v[r + 4];
        end
        return o;
    endfunction

endpackage

>>> rtl/led_matrix_frame_and_scan_core.sv
// A scan item passes the input register, then its row is held in the result register.
// Throughput: one item per cycle; only a scan waiting on a full, stalled
// result register holds the input register.
// Commands that change the frame wait in the input register, then write the frame buffer.
// Reset clears the frame buffer to all zero and empties both registers.
// ----------------------------------------------------------------------------
// led_matrix_frame_and_scan_core
// LED matrix frame buffer with font ROM, time scatter and row scan-out.
// ----------------------------------------------------------------------------
`include "led_matrix_frame_and_scan_core_assert.svh"

module led_matrix_frame_and_scan_core
    import lmfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] operation,
    input  logic [7:0] operand,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] row_pattern,
    output logic [7:0] column_enable
);

    lmfs_cmd_t  cmd;
    lmfs_scan_t scan;
    logic       cmd_valid;
    logic       out_free;
    logic       advance;
    logic       scan_load;

    // Non-scan items never wait on the result register.
    assign advance   = cmd_valid && (!scan.hit || out_free);
    assign scan_load = advance && scan.hit;

    lmfs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .operand   (operand),
        .advance   (advance),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    lmfs_frame_buf u_frame_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (advance),
        .cmd   (cmd),
        .scan  (scan)
    );

    lmfs_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (scan_load),
        .scan          (scan),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_pattern   (row_pattern),
        .column_enable (column_enable)
    );

    `LMFS_ASSERT_NEXT(a_scan_shows, scan_load, out_valid)
    `LMFS_ASSERT_NOW(a_stall_holds_item, in_stall, cmd_valid && scan.hit)
    `LMFS_ASSERT_NEXT(a_taken_drains, out_valid && !out_stall && !scan_load, !out_valid)

endmodule

>>> rtl/lmfs_in_stage.sv
// ----------------------------------------------------------------------------
// lmfs_in_stage
// Input register: holds one command item until the frame stage takes it.
// ----------------------------------------------------------------------------
module lmfs_in_stage
    import lmfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] operation,
    input  logic [7:0] operand,
    input  logic       advance,
    output logic       cmd_valid,
    output lmfs_cmd_t  cmd
);

    logic      valid_reg;
    logic      valid_next;
    lmfs_cmd_t cmd_reg;
    logic      take;

    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.op      <= operation;
            cmd_reg.operand <= operand;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

>>> rtl/lmfs_frame_buf.sv
// ----------------------------------------------------------------------------
// lmfs_frame_buf
// Five-row frame buffer: applies one command per cycle while apply is high and reads scan rows.
// ----------------------------------------------------------------------------
module lmfs_frame_buf
    import lmfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       apply,
    input  lmfs_cmd_t  cmd,
    output lmfs_scan_t scan
);

    frame_t           frame_reg;
    frame_t           frame_next;
    frame_t           dglyph;
    logic [ROW_W-1:0] sel;

    assign dglyph = digit_glyph(cmd.operand[3:0]);

    always_comb
    begin
        frame_next = frame_reg;
        unique case (lmfs_op_t'(cmd.op))
            OP_HOUR:     frame_next = scatter_bcd(frame_reg, cmd.operand, 3'd6);
            OP_MINUTE:   frame_next = scatter_bcd(frame_reg, cmd.operand, 3'd3);
            OP_SECOND:   frame_next = scatter_bcd(frame_reg, cmd.operand, 3'd0);
            OP_ADJ_HOUR:
                frame_next = scatter_bcd(letter_glyph(5'(CHAR_H - CHAR_A)), cmd.operand, 3'd0);
            OP_ADJ_MIN:
                frame_next = scatter_bcd(letter_glyph(5'(CHAR_M - CHAR_A)), cmd.operand, 3'd0);
            OP_ADJ_SEC:
                frame_next = scatter_bcd(letter_glyph(5'(CHAR_S - CHAR_A)), cmd.operand, 3'd0);
            OP_CHAR:
            begin
                // drop letters outside A..Z
                if (cmd.operand >= CHAR_A && cmd.operand <= CHAR_Z)
                begin
                    frame_next = letter_glyph(5'(cmd.operand - CHAR_A));
                end
            end
            OP_DIGIT:
            begin
                if (cmd.operand < NUM_DIGITS)
                begin
                    for (int r = 0; r < ROWS; r++)
                    begin
                        frame_next[r] = (frame_reg[r] & DIGIT_KEEP) | dglyph[r];
                    end
                end
            end
            OP_LOGO:     frame_next = LOGO;
            OP_CLEAR:    frame_next = '0;
            OP_SCAN:     frame_next = frame_reg;
            default:     frame_next = frame_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (apply)
        begin
            frame_reg <= frame_next;
        end
    end

    always_comb
    begin
        scan.hit           = (lmfs_op_t'(cmd.op) == OP_SCAN) && (cmd.operand < NUM_ROWS);
        sel                = scan.hit ? cmd.operand[ROW_W-1:0] : '0;
        scan.row_pattern   = frame_reg[sel];
        scan.column_enable = col_enable(sel);
    end

endmodule

>>> rtl/lmfs_out_stage.sv
// ----------------------------------------------------------------------------
// lmfs_out_stage
// Result register: holds one scanned row until the consumer takes it.
// ----------------------------------------------------------------------------
module lmfs_out_stage
    import lmfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  lmfs_scan_t scan,
    output logic       out_free,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] row_pattern,
    output logic [7:0] column_enable
);

    logic valid_reg;
    logic valid_next;
    row_t row_reg;
    row_t col_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= scan.row_pattern;
            col_reg <= scan.column_enable;
        end
    end

    assign out_valid     = valid_reg;
    assign row_pattern   = row_reg;
    assign column_enable = col_reg;

endmodule

>>> tb/led_matrix_frame_and_scan_core_tb.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_and_scan_core_tb
// Drives frame commands (time scatter, letters, digits, logo, clear, scan)
// into the core and checks every scanned row against a frame kept by the
// bench. Runs a directed pass and then random traffic under several
// sender-gap and receiver-stall mixes.
// ----------------------------------------------------------------------------
module led_matrix_frame_and_scan_core_tb;
    import lmfs_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_PER_PHASE = 481;

    localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    // Each glyph is five rows, top row (4) in the upper byte.
    localparam logic [26*40-1:0] LETTER_FONT = {
        40'h40A0E0A0A0, 40'hC0A0C0A0C0, 40'h40A080A040, 40'hC0A0A0A0C0,
        40'hE080E080E0, 40'hE080E08080, 40'h40A080E040, 40'hA0A0E0A0A0,
        40'h40404040E0, 40'h202020A040, 40'hA0C080C0A0, 40'h80808080E0,
        40'hA0E0A0A0A0, 40'hA0E0E0A0A0, 40'h40A0A0A040, 40'hC0A0C08080,
        40'h40A0A0A060, 40'hC0A0C0C0A0, 40'hE0804020E0, 40'hE0404040E0,
        40'hA0A0A0A0E0, 40'hA0A0A0A040, 40'hA0A0A0E0A0, 40'hA0A040A0A0,
        40'hA0A0404040, 40'hE0204080E0
    };
    localparam logic [10*40-1:0] DIGIT_FONT = {
        40'h0205050502, 40'h0202020202, 40'h0601020407, 40'h0601020106,
        40'h0505070101, 40'h0704060106, 40'h0204060502, 40'h0701020202,
        40'h0205020502, 40'h0205030102
    };
    localparam logic [39:0] LOGO_PICTURE  = 40'h629584B562;
    localparam logic [39:0] COLUMN_SELECT = 40'h7FBFFBFDFE;

    typedef struct packed {
        row_t row_pattern;
        row_t column_enable;
    } scan_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [3:0] operation;
    logic [7:0] operand;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] row_pattern;
    logic [7:0] column_enable;

    row_t      frame_model [ROWS];
    scan_row_t expected_scans [$];
    int        send_idle_pct;
    int        stall_pct;
    int        fail_count;
    int        cycle_count;

    led_matrix_frame_and_scan_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .operand       (operand),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_pattern   (row_pattern),
        .column_enable (column_enable)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- frame model

    task automatic scatter_time(input logic [7:0] v, input int low);
        for (int r = 0; r < 4; r++)
        begin
            frame_model[r][low]     = v[r];
            frame_model[r][low + 1] = v[r + 4];
        end
    endtask

    task automatic draw_letter(input logic [7:0] c);
        int         k;
        logic [39:0] glyph;
        k = int'(c - CHAR_A);
        glyph = LETTER_FONT[(25 - k) * 40 +: 40];
        for (int r = 0; r < ROWS; r++)
            frame_model[r] = glyph[8 * r +: 8];
    endtask

    task automatic update_frame(input logic [3:0] op, input logic [7:0] val);
        logic [39:0] glyph;
        scan_row_t   scanned;
        case (op)
            OP_HOUR:     scatter_time(val, 6);
            OP_MINUTE:   scatter_time(val, 3);
            OP_SECOND:   scatter_time(val, 0);
            OP_ADJ_HOUR:
            begin
                draw_letter(CHAR_H);
                scatter_time(val, 0);
            end
            OP_ADJ_MIN:
            begin
                draw_letter(CHAR_M);
                scatter_time(val, 0);
            end
            OP_ADJ_SEC:
            begin
                draw_letter(CHAR_S);
                scatter_time(val, 0);
            end
            OP_CHAR:
            begin
                if (val >= CHAR_A && val <= CHAR_Z)
                    draw_letter(val);
            end
            OP_DIGIT:
            begin
                if (val < NUM_DIGITS)
                begin
                    glyph = DIGIT_FONT[(9 - int'(val)) * 40 +: 40];
                    // merge into the low columns, keep the rest
                    for (int r = 0; r < ROWS; r++)
                        frame_model[r] = (frame_model[r] & DIGIT_KEEP) | glyph[8 * r +: 8];
                end
            end
            OP_LOGO:
                for (int r = 0; r < ROWS; r++)
                    frame_model[r] = LOGO_PICTURE[8 * r +: 8];
            OP_CLEAR:
                for (int r = 0; r < ROWS; r++)
                    frame_model[r] = '0;
            OP_SCAN:
            begin
                if (val < NUM_ROWS)
                begin
                    scanned.row_pattern   = frame_model[val];
                    scanned.column_enable = COLUMN_SELECT[8 * int'(val) +: 8];
                    expected_scans.push_back(scanned);
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- driving

    // Leave valid high after acceptance so back-to-back items need no toggle.
    task automatic send_cmd(input logic [3:0] op, input logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        operand   <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        update_frame(op, val);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        scan_row_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_scans.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected scan item: row_pattern=%h column_enable=%h",
                             row_pattern, column_enable);
            end
            else
            begin
                want = expected_scans.pop_front();
                if (row_pattern !== want.row_pattern ||
                    column_enable !== want.column_enable)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("scan mismatch: row exp %h got %h, col_en exp %h got %h",
                                 want.row_pattern, row_pattern,
                                 want.column_enable, column_enable);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d scans still pending", expected_scans.size());
            $display("** led_matrix_frame_and_scan_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_cmd(OP_LOGO, 8'h00);
        send_cmd(OP_SCAN, 8'd4);
        send_cmd(OP_SCAN, 8'd0);
        send_cmd(OP_HOUR, 8'hFF);
        send_cmd(OP_MINUTE, 8'h5A);
        send_cmd(OP_SECOND, 8'hA5);
        send_cmd(OP_SCAN, 8'd3);
        send_cmd(OP_ADJ_HOUR, 8'h12);
        send_cmd(OP_SCAN, 8'd4);
        send_cmd(OP_ADJ_MIN, 8'h00);
        send_cmd(OP_ADJ_SEC, 8'h59);
        send_cmd(OP_CHAR, CHAR_A);
        send_cmd(OP_CHAR, CHAR_Z);
        // neighbors of the letter range and lower case must be dropped
        send_cmd(OP_CHAR, CHAR_A - 8'd1);
        send_cmd(OP_CHAR, CHAR_Z + 8'd1);
        send_cmd(OP_CHAR, 8'h61);
        send_cmd(OP_SCAN, 8'd4);
        send_cmd(OP_DIGIT, 8'd9);
        send_cmd(OP_DIGIT, NUM_DIGITS);
        send_cmd(OP_SCAN, 8'd0);
        send_cmd(OP_CLEAR, 8'hFF);
        send_cmd(OP_SCAN, NUM_ROWS);
        send_cmd(OP_SCAN, 8'hFF);
        send_cmd(OP_UNUSED_LAST, 8'h00);
        send_cmd(OP_UNUSED_FIRST, 8'hFF);
    endtask

    task automatic run_random(input int count);
        int         done;
        int         pick;
        logic [3:0] op;
        logic [7:0] val;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            val  = 8'($urandom_range(255));
            if (pick < 34)
            begin
                op = OP_SCAN;
                if ($urandom_range(9) != 0)
                    val = 8'($urandom_range(ROWS - 1));
            end
            else if (pick < 46)
                op = 4'($urandom_range(OP_SECOND, OP_HOUR));
            else if (pick < 56)
                op = 4'($urandom_range(OP_ADJ_SEC, OP_ADJ_HOUR));
            else if (pick < 68)
            begin
                op = OP_CHAR;
                if ($urandom_range(4) != 0)
                    val = CHAR_A + 8'($urandom_range(25));
            end
            else if (pick < 84)
            begin
                op = OP_DIGIT;
                if ($urandom_range(4) != 0)
                    val = 8'($urandom_range(9));
            end
            else if (pick < 89)
                op = OP_LOGO;
            else if (pick < 92)
                op = OP_CLEAR;
            else
                op = 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            send_cmd(op, val);
            done++;
        end
    endtask

    task automatic test_stream_no_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(RANDOM_PER_PHASE);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 82;
        stall_pct     = 0;
        run_random(RANDOM_PER_PHASE);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct     = 82;
        run_random(RANDOM_PER_PHASE);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 36;
        stall_pct     = 36;
        run_random(RANDOM_PER_PHASE);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= '0;
        operand   <= '0;
        out_stall <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        fail_count    = 0;
        cycle_count   = 0;
        for (int r = 0; r < ROWS; r++)
            frame_model[r] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_stream_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        in_valid <= 1'b0;
        while (expected_scans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** led_matrix_frame_and_scan_core: PASSED **");
        else
            $display("** led_matrix_frame_and_scan_core: FAILED **");
        $finish;
    end

endmodule
